// ===== sv/iokv_pkg.sv =====
package iokv_pkg;

    localparam int ENTRIES    = 64;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 64;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int POS_W      = 6;
    localparam int FUNC_W     = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_SET     = 3'd0,
        FN_GET     = 3'd1,
        FN_REMOVE  = 3'd2,
        FN_REPLACE = 3'd3,
        FN_AT      = 3'd4,
        FN_CLEAR   = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } state_t;

    // broadcast to every cell
    typedef struct packed {
        logic                  clear;
        logic [KEY_BITS-1:0]   cmp_key;
        logic [KEY_BITS-1:0]   cmp_new_key;
        logic [KEY_BITS-1:0]   wr_key_data;
        logic [VALUE_BITS-1:0] wr_value_data;
    } cell_cmd_t;

    // per-cell write strobes
    typedef struct packed {
        logic wr_key;
        logic wr_value;
        logic set_live;
        logic kill;
    } cell_wr_t;

endpackage

// ===== sv/iokv_cell.sv =====
module iokv_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  iokv_pkg::cell_cmd_t              cmd,
    input  iokv_pkg::cell_wr_t               wr,
    input  logic                             scan_in_valid,
    input  logic [iokv_pkg::POS_W-1:0]       scan_in_rank,
    output logic                             scan_out_valid,
    output logic [iokv_pkg::POS_W-1:0]       scan_out_rank,
    output logic                             hit,
    output logic                             match_key,
    output logic                             match_new_key,
    output logic [iokv_pkg::KEY_BITS-1:0]    slot_key,
    output logic [iokv_pkg::VALUE_BITS-1:0]  slot_value
);

    logic [iokv_pkg::KEY_BITS-1:0]   key_reg;
    logic [iokv_pkg::VALUE_BITS-1:0] value_reg;
    logic                            live_reg;
    logic                            live_next;
    logic                            scan_valid_reg;
    logic                            scan_valid_next;
    logic [iokv_pkg::POS_W-1:0]      scan_rank_reg;
    logic [iokv_pkg::POS_W-1:0]      scan_rank_next;

    always_comb
    begin
        live_next = live_reg;
        if (cmd.clear)
        begin
            live_next = 1'b0;
        end
        else if (wr.set_live)
        begin
            live_next = 1'b1;
        end
        else if (wr.kill)
        begin
            live_next = 1'b0;
        end
    end

    assign match_key     = live_reg && (key_reg == cmd.cmp_key);
    assign match_new_key = live_reg && (key_reg == cmd.cmp_new_key);

    // rank wave: stops at the cell where the remaining rank reaches zero
    assign hit             = scan_in_valid && live_reg && (scan_in_rank == '0);
    assign scan_valid_next = scan_in_valid && !hit;
    assign scan_rank_next  = scan_in_rank - iokv_pkg::POS_W'(live_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg       <= 1'b0;
            scan_valid_reg <= 1'b0;
        end
        else
        begin
            live_reg       <= live_next;
            scan_valid_reg <= scan_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_rank_reg <= scan_rank_next;
        if (wr.wr_key)
        begin
            key_reg <= cmd.wr_key_data;
        end
        if (wr.wr_value)
        begin
            value_reg <= cmd.wr_value_data;
        end
    end

    assign scan_out_valid = scan_valid_reg;
    assign scan_out_rank  = scan_rank_reg;
    assign slot_key       = key_reg;
    assign slot_value     = value_reg;

endmodule

// ===== sv/insertion_ordered_key_value_table_top.sv =====
// Set, get, remove, replace-key and clear step through the match, execute and
// done states; entry-at goes from match to done once the rank wave hits a live
// cell or leaves the chain (at most ENTRIES cells), as the wave steps one cell
// of the slot chain per cycle. One transaction is handled at a time.
// Reset clears all live bits, the slot count, the rank wave and the output valid flag;
// slot keys and values are not reset.
module insertion_ordered_key_value_table_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [iokv_pkg::FUNC_W-1:0]       func,
    input  logic [63:0]                       key,
    input  logic [63:0]                       new_value,
    input  logic [63:0]                       new_key,
    input  logic [iokv_pkg::POS_W-1:0]        position,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              success,
    output logic                              table_full,
    output logic [63:0]                       found_key,
    output logic [63:0]                       found_value
);

    localparam int N = iokv_pkg::ENTRIES;

    iokv_pkg::state_t state_reg, state_next;

    logic [iokv_pkg::FUNC_W-1:0]     func_reg;
    logic [iokv_pkg::KEY_BITS-1:0]   key_reg;
    logic [iokv_pkg::KEY_BITS-1:0]   new_key_reg;
    logic [iokv_pkg::VALUE_BITS-1:0] value_reg;
    logic [iokv_pkg::POS_W-1:0]      pos_reg;
    logic [iokv_pkg::CNT_W-1:0]      slots_used_reg, slots_used_next;

    logic [N-1:0] match_k_reg, match_nk_reg;
    logic [N-1:0] match_k, match_nk, hit_vec;

    logic [iokv_pkg::KEY_BITS-1:0]   cell_key [N];
    logic [iokv_pkg::VALUE_BITS-1:0] cell_value [N];
    logic                            scan_v [N+1];
    logic [iokv_pkg::POS_W-1:0]      scan_r [N+1];

    iokv_pkg::cell_cmd_t cmd;
    iokv_pkg::cell_wr_t  wr [N];

    logic                            res_ok_reg, res_ok_next;
    logic                            res_full_reg, res_full_next;
    logic [iokv_pkg::KEY_BITS-1:0]   res_key_reg, res_key_next;
    logic [iokv_pkg::VALUE_BITS-1:0] res_value_reg, res_value_next;

    logic                            out_valid_reg, out_valid_next;
    logic                            success_reg;
    logic                            full_reg;
    logic [63:0]                     found_key_reg;
    logic [63:0]                     found_value_reg;

    logic [iokv_pkg::VALUE_BITS-1:0] match_value;
    logic [iokv_pkg::KEY_BITS-1:0]   hit_key;
    logic [iokv_pkg::VALUE_BITS-1:0] hit_value;
    logic                            any_k, any_nk, any_hit;
    logic                            is_full;
    logic                            do_append, do_update, do_kill, do_rename, do_clear;
    logic                            out_load;

    assign in_stall = (state_reg != iokv_pkg::ST_IDLE);
    assign out_load = (state_reg == iokv_pkg::ST_DONE) && (!out_valid_reg || !out_stall);

    // slot chain; the wave enters cell 0 in the match cycle
    assign scan_v[0] = (state_reg == iokv_pkg::ST_MATCH) && (func_reg == iokv_pkg::FN_AT);
    assign scan_r[0] = pos_reg;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : gen_cell
            iokv_cell u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .cmd           (cmd),
                .wr            (wr[g]),
                .scan_in_valid (scan_v[g]),
                .scan_in_rank  (scan_r[g]),
                .scan_out_valid(scan_v[g+1]),
                .scan_out_rank (scan_r[g+1]),
                .hit           (hit_vec[g]),
                .match_key     (match_k[g]),
                .match_new_key (match_nk[g]),
                .slot_key      (cell_key[g]),
                .slot_value    (cell_value[g])
            );
        end
    endgenerate

    always_comb
    begin
        match_value = '0;
        hit_key     = '0;
        hit_value   = '0;
        for (int i = 0; i < N; i++)
        begin
            match_value = match_value | ({iokv_pkg::VALUE_BITS{match_k_reg[i]}} & cell_value[i]);
            hit_key     = hit_key | ({iokv_pkg::KEY_BITS{hit_vec[i]}} & cell_key[i]);
            hit_value   = hit_value | ({iokv_pkg::VALUE_BITS{hit_vec[i]}} & cell_value[i]);
        end
    end

    assign any_k   = |match_k_reg;
    assign any_nk  = |match_nk_reg;
    assign any_hit = |hit_vec;
    assign is_full = (slots_used_reg == iokv_pkg::CNT_W'(N));

    // operation decode in the execute cycle
    always_comb
    begin
        do_append = 1'b0;
        do_update = 1'b0;
        do_kill   = 1'b0;
        do_rename = 1'b0;
        do_clear  = 1'b0;
        if (state_reg == iokv_pkg::ST_EXEC)
        begin
            case (func_reg)
                iokv_pkg::FN_SET:
                begin
                    do_update = any_k;
                    do_append = !any_k && !is_full;
                end
                iokv_pkg::FN_REMOVE:  do_kill   = any_k;
                iokv_pkg::FN_REPLACE: do_rename = any_k && (key_reg != new_key_reg) && !any_nk;
                iokv_pkg::FN_CLEAR:   do_clear  = 1'b1;
                default:              do_clear  = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        cmd.clear         = do_clear;
        cmd.cmp_key       = key_reg;
        cmd.cmp_new_key   = new_key_reg;
        cmd.wr_key_data   = do_rename ? new_key_reg : key_reg;
        cmd.wr_value_data = value_reg;
        for (int i = 0; i < N; i++)
        begin
            wr[i].set_live = do_append && (slots_used_reg[iokv_pkg::IDX_W-1:0]
                                           == iokv_pkg::IDX_W'(i));
            wr[i].wr_key   = wr[i].set_live || (do_rename && match_k_reg[i]);
            wr[i].wr_value = wr[i].set_live || (do_update && match_k_reg[i]);
            wr[i].kill     = do_kill && match_k_reg[i];
        end
    end

    always_comb
    begin
        slots_used_next = slots_used_reg;
        if (do_clear)
        begin
            slots_used_next = '0;
        end
        else if (do_append)
        begin
            slots_used_next = slots_used_reg + 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            iokv_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = iokv_pkg::ST_MATCH;
                end
            end
            iokv_pkg::ST_MATCH:
            begin
                if (func_reg == iokv_pkg::FN_AT)
                begin
                    state_next = any_hit ? iokv_pkg::ST_DONE : iokv_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = iokv_pkg::ST_EXEC;
                end
            end
            iokv_pkg::ST_EXEC: state_next = iokv_pkg::ST_DONE;
            iokv_pkg::ST_SCAN:
            begin
                if (any_hit || scan_v[N])
                begin
                    state_next = iokv_pkg::ST_DONE;
                end
            end
            iokv_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = iokv_pkg::ST_IDLE;
                end
            end
            default: state_next = iokv_pkg::ST_IDLE;
        endcase
    end

    // result staging
    always_comb
    begin
        res_ok_next    = res_ok_reg;
        res_full_next  = res_full_reg;
        res_key_next   = res_key_reg;
        res_value_next = res_value_reg;
        case (state_reg)
            iokv_pkg::ST_EXEC:
            begin
                res_ok_next    = 1'b0;
                res_full_next  = 1'b0;
                res_key_next   = '0;
                res_value_next = '0;
                case (func_reg)
                    iokv_pkg::FN_SET:
                    begin
                        res_ok_next   = do_append;
                        res_full_next = !any_k && is_full;
                    end
                    iokv_pkg::FN_GET, iokv_pkg::FN_REMOVE:
                    begin
                        res_ok_next    = any_k;
                        res_value_next = match_value;
                    end
                    iokv_pkg::FN_REPLACE:
                        res_ok_next = any_k && ((key_reg == new_key_reg) || !any_nk);
                    iokv_pkg::FN_CLEAR: res_ok_next = 1'b1;
                    default:            res_ok_next = 1'b0;
                endcase
            end
            iokv_pkg::ST_MATCH, iokv_pkg::ST_SCAN:
            begin
                res_ok_next    = any_hit;
                res_full_next  = 1'b0;
                res_key_next   = hit_key;
                res_value_next = hit_value;
            end
            default:
            begin
                res_ok_next = res_ok_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= iokv_pkg::ST_IDLE;
            slots_used_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slots_used_reg <= slots_used_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            func_reg    <= func;
            key_reg     <= key[iokv_pkg::KEY_BITS-1:0];
            new_key_reg <= new_key[iokv_pkg::KEY_BITS-1:0];
            value_reg   <= new_value[iokv_pkg::VALUE_BITS-1:0];
            pos_reg     <= position;
        end
        if (state_reg == iokv_pkg::ST_MATCH)
        begin
            match_k_reg  <= match_k;
            match_nk_reg <= match_nk;
        end
        res_ok_reg    <= res_ok_next;
        res_full_reg  <= res_full_next;
        res_key_reg   <= res_key_next;
        res_value_reg <= res_value_next;
        if (out_load)
        begin
            success_reg     <= res_ok_reg;
            full_reg        <= res_full_reg;
            found_key_reg   <= 64'(res_key_reg);
            found_value_reg <= 64'(res_value_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign success     = success_reg;
    assign table_full  = full_reg;
    assign found_key   = found_key_reg;
    assign found_value = found_value_reg;

    a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == iokv_pkg::ST_EXEC |-> $onehot0(match_k_reg))
        else $error("more than one live slot holds the key");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("rank wave hit more than one cell");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        slots_used_reg <= iokv_pkg::CNT_W'(N))
        else $error("slot count past capacity");

    a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_clear |=> slots_used_reg == '0)
        else $error("clear left slots in use");

    a_scan_only: assert property (@(posedge clk) disable iff (!rst_n)
        any_hit |-> (state_reg == iokv_pkg::ST_SCAN) || (state_reg == iokv_pkg::ST_MATCH))
        else $error("rank wave outside entry-at");

endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [iokv_pkg::FUNC_W-1:0] func = '0;
    logic [63:0] key = '0;
    logic [63:0] new_value = '0;
    logic [63:0] new_key = '0;
    logic [iokv_pkg::POS_W-1:0] position = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic success;
    logic table_full;
    logic [63:0] found_key;
    logic [63:0] found_value;

    typedef struct packed {
        logic        ok;
        logic        full;
        logic [63:0] fkey;
        logic [63:0] fval;
    } reply_t;

    logic [iokv_pkg::KEY_BITS-1:0]   tbl_key [iokv_pkg::ENTRIES];
    logic [iokv_pkg::VALUE_BITS-1:0] tbl_val [iokv_pkg::ENTRIES];
    logic                            tbl_live [iokv_pkg::ENTRIES];
    int unsigned                     tbl_used;
    reply_t                          pending_replies [$];
    int unsigned                     fail_count = 0;
    int unsigned                     idle_cycles = 0;
    bit                              hold_off = 1'b0;
    logic [63:0]                     key_pool [$];

    insertion_ordered_key_value_table_top DUT (.*);

    always #2 clk = ~clk;

    function automatic int find_slot(logic [63:0] k);
        for (int i = 0; i < tbl_used && i < iokv_pkg::ENTRIES; i++)
            if (tbl_live[i] && tbl_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic reply_t apply_op(logic [2:0] f, logic [63:0] k, logic [63:0] v,
                                        logic [63:0] nk, logic [5:0] p);
        reply_t r;
        int s;
        int unsigned rank;
        r = '0;
        case (f)
            iokv_pkg::FN_SET:
            begin
                s = find_slot(k);
                if (s >= 0)
                    tbl_val[s] = v;
                else if (tbl_used >= iokv_pkg::ENTRIES)
                    r.full = 1'b1;
                else
                begin
                    tbl_key[tbl_used] = k;
                    tbl_val[tbl_used] = v;
                    tbl_live[tbl_used] = 1'b1;
                    tbl_used++;
                    r.ok = 1'b1;
                end
            end
            iokv_pkg::FN_GET, iokv_pkg::FN_REMOVE:
            begin
                s = find_slot(k);
                if (s >= 0)
                begin
                    r.ok = 1'b1;
                    r.fval = tbl_val[s];
                    if (f == iokv_pkg::FN_REMOVE)
                        tbl_live[s] = 1'b0;
                end
            end
            iokv_pkg::FN_REPLACE:
            begin
                s = find_slot(k);
                if (s >= 0)
                begin
                    if (k == nk)
                        r.ok = 1'b1;
                    else if (find_slot(nk) < 0)
                    begin
                        tbl_key[s] = nk;
                        r.ok = 1'b1;
                    end
                end
            end
            iokv_pkg::FN_AT:
            begin
                rank = 0;
                for (int i = 0; i < tbl_used && i < iokv_pkg::ENTRIES; i++)
                begin
                    if (tbl_live[i])
                    begin
                        if (rank == p && !r.ok)
                        begin
                            r.ok = 1'b1;
                            r.fkey = tbl_key[i];
                            r.fval = tbl_val[i];
                        end
                        rank++;
                    end
                end
            end
            iokv_pkg::FN_CLEAR:
            begin
                for (int i = 0; i < iokv_pkg::ENTRIES; i++)
                    tbl_live[i] = 1'b0;
                tbl_used = 0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_op(logic [2:0] f, logic [63:0] k, logic [63:0] v = '0,
                           logic [63:0] nk = '0, logic [5:0] p = '0, int gap = -1);
        int g;
        g = (gap < 0) ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11)) : gap;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        key <= k;
        new_value <= v;
        new_key <= nk;
        position <= p;
        do
            @(posedge clk);
        while (in_stall);
        pending_replies = {pending_replies, apply_op(f, k, v, nk, p)};
    endtask

    // receiver: random stalls plus an optional long hold-off
    initial
    begin
        int w;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            else
            begin
                w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
                out_stall <= (w > 0);
                if (w > 0)
                begin
                    repeat (w - 1) @(posedge clk);
                    if (!hold_off)
                        out_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        reply_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected result expected none actual ok=%0b", $time, success);
                fail_count++;
            end
            else
            begin
                exp_r = pending_replies.pop_front();
                if (success !== exp_r.ok)
                begin
                    $display("%0t: success expected %0b actual %0b", $time, exp_r.ok, success);
                    fail_count++;
                end
                if (table_full !== exp_r.full)
                begin
                    $display("%0t: table_full expected %0b actual %0b", $time, exp_r.full,
                             table_full);
                    fail_count++;
                end
                if (found_key !== exp_r.fkey)
                begin
                    $display("%0t: found_key expected %h actual %h", $time, exp_r.fkey,
                             found_key);
                    fail_count++;
                end
                if (found_value !== exp_r.fval)
                begin
                    $display("%0t: found_value expected %h actual %h", $time, exp_r.fval,
                             found_value);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_key();
        if (key_pool.size() > 0 && $urandom_range(0, 9) < 8)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return rand64();
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        wait (pending_replies.size() == 0);
        repeat (80) @(posedge clk);
    endtask

    task automatic test_directed();
        send_op(iokv_pkg::FN_GET, 64'd5);
        send_op(iokv_pkg::FN_SET, 64'd0, 64'd0);
        send_op(iokv_pkg::FN_SET, '1, '1);
        send_op(iokv_pkg::FN_SET, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_op(iokv_pkg::FN_SET, '1, 64'h1234);
        send_op(iokv_pkg::FN_GET, '1);
        send_op(iokv_pkg::FN_AT, '0, '0, '0, 6'd0);
        send_op(iokv_pkg::FN_AT, '0, '0, '0, 6'd2);
        send_op(iokv_pkg::FN_AT, '0, '0, '0, 6'd63);
        send_op(iokv_pkg::FN_REPLACE, 64'd0, '0, 64'd0);
        send_op(iokv_pkg::FN_REPLACE, 64'd0, '0, '1);
        send_op(iokv_pkg::FN_REPLACE, 64'd0, '0, 64'hAAAA_AAAA_AAAA_AAAA);
        send_op(iokv_pkg::FN_REPLACE, 64'd77, '0, 64'd78);
        send_op(iokv_pkg::FN_REMOVE, '1);
        send_op(iokv_pkg::FN_REMOVE, '1);
        send_op(iokv_pkg::FN_AT, '0, '0, '0, 6'd1);
        send_op(iokv_pkg::FN_SET, '1, 64'd9);
        send_op(3'd6, '1, '1, '1, '1);
        send_op(3'd7, '1, '1, '1, '1);
        send_op(iokv_pkg::FN_CLEAR, '0);
        send_op(iokv_pkg::FN_GET, 64'd0);
    endtask

    task automatic test_fill_and_full();
        for (int i = 0; i < iokv_pkg::ENTRIES; i++)
            send_op(iokv_pkg::FN_SET, 64'h100 + i, rand64(), '0, '0, 0);
        send_op(iokv_pkg::FN_SET, 64'hFFFF, 64'd1);
        send_op(iokv_pkg::FN_REMOVE, 64'h100);
        send_op(iokv_pkg::FN_SET, 64'hFFFF, 64'd1);
        send_op(iokv_pkg::FN_AT, '0, '0, '0, 6'd62);
        send_op(iokv_pkg::FN_AT, '0, '0, '0, 6'd63);
        send_op(iokv_pkg::FN_CLEAR, '0);
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 12; i++)
            send_op(iokv_pkg::FN_SET, rand64(), rand64(), '0, '0, 0);
        wait (!hold_off);
        drain();
    endtask

    task automatic test_random(int n);
        logic [2:0] f;
        logic [63:0] k;
        int r;
        for (int i = 0; i < n; i++)
        begin
            if (key_pool.size() < 24)
                key_pool = {key_pool, rand64()};
            r = $urandom_range(0, 99);
            f = (r < 35) ? iokv_pkg::FN_SET : (r < 50) ? iokv_pkg::FN_GET :
                (r < 65) ? iokv_pkg::FN_REMOVE : (r < 77) ? iokv_pkg::FN_REPLACE :
                (r < 94) ? iokv_pkg::FN_AT : (r < 97) ? iokv_pkg::FN_CLEAR :
                3'($urandom_range(0, 7));
            k = pick_key();
            send_op(f, k, rand64(), ($urandom_range(0, 5) == 0) ? k : pick_key(),
                    6'($urandom_range(0, tbl_used + 2)));
            if (i % 150 == 149)
                drain();
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_and_full();
        drain();
        test_backpressure();
        test_random(350);
        drain();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
sv/iokv_pkg.sv
sv/iokv_cell.sv
sv/insertion_ordered_key_value_table_top.sv
tb/testbench.sv
